// File: hdl/dense_layer_sigmoid_macros.svh
// Assertion helpers used by the dense layer top module.
`ifndef DENSE_LAYER_SIGMOID_MACROS_SVH
`define DENSE_LAYER_SIGMOID_MACROS_SVH

// Check a condition at every clock edge outside reset
`define DLS_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle
`define DLS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: hdl/dls_pkg.sv
package dls_pkg;

    localparam int MAX_INPUTS  = 16;
    localparam int MAX_OUTPUTS = 16;
    localparam int WMEM_DEPTH  = MAX_OUTPUTS * (MAX_INPUTS + 1);
    localparam int WMEM_AW     = $clog2(WMEM_DEPTH);
    localparam int XIDX_W      = $clog2(MAX_INPUTS);
    localparam int NIDX_W      = $clog2(MAX_OUTPUTS);
    localparam int COUNT_W     = 5;
    localparam int ACC_W       = 36;
    localparam int PROD_W      = 32;

    // Operation codes
    localparam logic OP_WEIGHT = 1'b0;
    localparam logic OP_INPUT  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_INPUT_COUNT  = 1'b0;
    localparam logic CFG_OUTPUT_COUNT = 1'b1;

    localparam logic [63:0] EXP_STEP = 64'd4162825044;

    typedef struct packed {
        logic               op;
        logic [8:0]         weight_address;
        logic signed [15:0] value;
    } dls_in_t;

    typedef struct packed {
        logic [3:0]  neuron_index;
        logic [15:0] activation;
        logic        last_out;
    } dls_out_t;

    // One term handed to the multiply-accumulate unit
    typedef struct packed {
        logic valid;
        logic bias;
        logic first;
    } dls_mac_req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ACT
    } dls_state_t;

    typedef logic [15:0] sig_table_t [256];

    // Logistic table over the signed top byte of a Q4.12 value, centre (2k+1)/32
    function automatic sig_table_t build_sig_table();
        logic [63:0] epow [256];
        logic [63:0] p;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] q;
        sig_table_t  tbl;
        int          k;
        int          mm;
        int          m;
        int          i;
        int          b;
        p = 64'h1_0000_0000;
        epow[0] = p;
        for (m = 1; m < 256; m++) begin
            p = (p * EXP_STEP) >> 32;
            epow[m] = p;
        end
        for (i = 0; i < 256; i++) begin
            k   = (i < 128) ? i : i - 256;
            mm  = (k >= 0) ? (2 * k + 1) : (-2 * k - 1);
            e   = epow[mm];
            den = 64'h1_0000_0000 + e;
            num = (k >= 0) ? 64'h1_0000_0000_0000 : (e << 16);
            num = num + (den >> 1);
            // restoring long division, round half up through the added half
            rem = '0;
            q   = '0;
            for (b = 63; b >= 0; b--) begin
                rem = {rem[62:0], num[b]};
                if (rem >= den) begin
                    rem  = rem - den;
                    q[b] = 1'b1;
                end
            end
            if (q > 64'd65535) begin
                q = 64'd65535;
            end
            tbl[i] = q[15:0];
        end
        return tbl;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

// File: hdl/dls_mac.sv
module dls_mac
    import dls_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  dls_mac_req_t             req,
    input  logic signed [15:0]       weight,
    input  logic signed [15:0]       x,
    output logic signed [ACC_W-1:0]  acc,
    output logic                     busy
);

    dls_mac_req_t             s1_req_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] prod_next;

    // Bias enters as Q8.24, weights times inputs as plain products
    always_comb begin
        if (req.bias) begin
            prod_next = {{(PROD_W-28){weight[15]}}, weight, 12'b0};
        end else begin
            prod_next = weight * x;
        end
    end

    // Track which stage holds a live term
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_req_reg <= '0;
        end else begin
            s1_req_reg <= req;
        end
    end

    // Product stage
    always_ff @(posedge aclk) begin
        if (req.valid) begin
            prod_reg <= prod_next;
        end
    end

    // Accumulate stage, restart on the first term of a neuron
    always_ff @(posedge aclk) begin
        if (s1_req_reg.valid) begin
            if (s1_req_reg.first) begin
                acc_reg <= ACC_W'(prod_reg);
            end else begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    assign acc  = acc_reg;
    assign busy = s1_req_reg.valid;

endmodule

// File: hdl/dense_layer_sigmoid.sv
// Weight writes and input elements are accepted through s_valid/s_ready; s_ready drops while a vector runs.
// Completing a vector of n inputs starts the shared multiply-accumulate: each neuron issues
// n+1 weight reads through the single memory port, drains the pipeline, then looks up its
// activation, which waits until the output register is free.
// Synchronous active-low reset clears the sequencer, counters and counts (both to 16);
// the weight memory and input store are left as they are.
`include "dense_layer_sigmoid_macros.svh"

module dense_layer_sigmoid
    import dls_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [4:0]   cfg_wdata,
    input  logic         s_valid,
    output logic         s_ready,
    input  dls_in_t      s_data,
    output logic         m_valid,
    input  logic         m_ready,
    output dls_out_t     m_data
);

    dls_state_t              state_reg;
    dls_state_t              state_next;
    logic [COUNT_W-1:0]      n_reg;
    logic [COUNT_W-1:0]      nout_reg;
    logic [COUNT_W-1:0]      cfg_clamped;
    logic [COUNT_W-1:0]      elem_cnt_reg;
    logic [COUNT_W-1:0]      elem_cnt_next;
    logic [COUNT_W-1:0]      elem_slot;
    logic [COUNT_W-1:0]      i_reg;
    logic [COUNT_W-1:0]      i_next;
    logic [NIDX_W-1:0]       o_reg;
    logic [NIDX_W-1:0]       o_next;
    logic [WMEM_AW-1:0]      base_reg;
    logic [WMEM_AW-1:0]      base_next;
    logic [WMEM_AW-1:0]      rd_addr;
    logic signed [15:0]      x_store_reg [MAX_INPUTS];
    logic [15:0]             wmem [WMEM_DEPTH];
    logic signed [15:0]      rd_data_reg;
    logic signed [15:0]      tag_x_reg;
    dls_mac_req_t            tag_req_reg;
    dls_mac_req_t            issue_req;
    logic signed [ACC_W-1:0] mac_acc;
    logic                    mac_busy;
    logic                    in_fire;
    logic                    load_out;
    logic                    out_free;
    logic                    last_neuron;
    logic signed [23:0]      acc_q;
    logic signed [15:0]      sum_sat;
    logic                    m_valid_reg;
    dls_out_t                m_data_reg;

    assign in_fire  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign rd_addr  = base_reg + WMEM_AW'(i_reg);
    assign last_neuron = ({1'b0, o_reg} == (nout_reg - COUNT_W'(1)));

    // Clamp a written count to 1..16
    always_comb begin
        priority if (cfg_wdata == '0) begin
            cfg_clamped = COUNT_W'(1);
        end else if (cfg_wdata > COUNT_W'(MAX_INPUTS)) begin
            cfg_clamped = COUNT_W'(MAX_INPUTS);
        end else begin
            cfg_clamped = cfg_wdata;
        end
    end

    // Slot for the next input element
    assign elem_slot = (elem_cnt_reg >= n_reg) ? '0 : elem_cnt_reg;

    // Floor-shift the Q12.24 sum to Q4.12 and saturate
    assign acc_q = mac_acc[ACC_W-1:12];
    always_comb begin
        priority if (acc_q > 24'sd32767) begin
            sum_sat = 16'sh7fff;
        end else if (acc_q < -24'sd32768) begin
            sum_sat = -16'sh8000;
        end else begin
            sum_sat = acc_q[15:0];
        end
    end

    // Sequencer: next state and per-cycle controls
    always_comb begin
        state_next    = state_reg;
        i_next        = i_reg;
        o_next        = o_reg;
        base_next     = base_reg;
        elem_cnt_next = elem_cnt_reg;
        issue_req     = '0;
        load_out      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && s_data.op == OP_INPUT) begin
                    if (elem_slot + COUNT_W'(1) >= n_reg) begin
                        elem_cnt_next = '0;
                        i_next        = '0;
                        o_next        = '0;
                        base_next     = '0;
                        state_next    = ST_MAC;
                    end else begin
                        elem_cnt_next = elem_slot + COUNT_W'(1);
                    end
                end
                if (cfg_we) begin
                    elem_cnt_next = '0;
                end
            end
            ST_MAC: begin
                issue_req.valid = 1'b1;
                issue_req.bias  = (i_reg == n_reg);
                issue_req.first = (i_reg == '0);
                if (i_reg == n_reg) begin
                    state_next = ST_DRAIN;
                end else begin
                    i_next = i_reg + COUNT_W'(1);
                end
            end
            ST_DRAIN: begin
                if (!tag_req_reg.valid && !mac_busy) begin
                    state_next = ST_ACT;
                end
            end
            ST_ACT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (last_neuron) begin
                        state_next = ST_IDLE;
                    end else begin
                        o_next     = o_reg + NIDX_W'(1);
                        base_next  = base_reg + WMEM_AW'(n_reg) + WMEM_AW'(1);
                        i_next     = '0;
                        state_next = ST_MAC;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            n_reg        <= COUNT_W'(MAX_INPUTS);
            nout_reg     <= COUNT_W'(MAX_OUTPUTS);
            elem_cnt_reg <= '0;
            i_reg        <= '0;
            o_reg        <= '0;
            base_reg     <= '0;
            tag_req_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            elem_cnt_reg <= elem_cnt_next;
            i_reg        <= i_next;
            o_reg        <= o_next;
            base_reg     <= base_next;
            tag_req_reg  <= issue_req;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_INPUT_COUNT:  n_reg    <= cfg_clamped;
                    CFG_OUTPUT_COUNT: nout_reg <= cfg_clamped;
                    default: ;
                endcase
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Weight memory: write on an in-range weight request, read one term a cycle
    always_ff @(posedge aclk) begin
        if (in_fire && s_data.op == OP_WEIGHT
                && s_data.weight_address < WMEM_AW'(WMEM_DEPTH)) begin
            wmem[s_data.weight_address] <= s_data.value;
        end
        if (issue_req.valid) begin
            rd_data_reg <= wmem[rd_addr];
        end
    end

    // Input store and the input value travelling with each read
    always_ff @(posedge aclk) begin
        if (in_fire && s_data.op == OP_INPUT) begin
            x_store_reg[elem_slot[XIDX_W-1:0]] <= s_data.value;
        end
        if (issue_req.valid) begin
            tag_x_reg <= x_store_reg[i_reg[XIDX_W-1:0]];
        end
    end

    dls_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (tag_req_reg),
        .weight  (rd_data_reg),
        .x       (tag_x_reg),
        .acc     (mac_acc),
        .busy    (mac_busy)
    );

    // Result register: hold until taken
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg.neuron_index <= o_reg;
            m_data_reg.activation   <= SIG_TABLE[sum_sat[15:8]];
            m_data_reg.last_out     <= last_neuron;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `DLS_ASSERT_ALWAYS(a_elem_cnt_range, elem_cnt_reg < n_reg, "element counter past input count")
    `DLS_ASSERT_IMPLIES(a_act_drained, state_reg == ST_ACT, !tag_req_reg.valid && !mac_busy, "activation taken before sum complete")
    `DLS_ASSERT_IMPLIES(a_idle_drained, state_reg == ST_IDLE, !tag_req_reg.valid && !mac_busy, "terms in flight while idle")

endmodule

// File: tb/tb_dense_layer_sigmoid.sv
module tb_dense_layer_sigmoid
    import dls_pkg::*;
;

    localparam longint unsigned EXP_DECAY      = 64'd4162825044;
    localparam int              SETTLE_CYCLES  = 32;
    localparam int              LONG_HOLD      = 800;
    localparam int              WATCHDOG_LIMIT = 5000;
    localparam int              PHASE_ITEMS    = 14;

    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     cfg_we    = 1'b0;
    logic     cfg_index = CFG_INPUT_COUNT;
    logic [4:0] cfg_wdata = '0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    dls_in_t  s_data    = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    dls_out_t m_data;

    // Shadow of the layer: weights, held elements, counts
    logic signed [15:0] weight_shadow [WMEM_DEPTH];
    bit                 weight_loaded [WMEM_DEPTH];
    logic signed [15:0] element_shadow [MAX_INPUTS];
    int unsigned        elements_held;
    logic [4:0]         input_count_reg;
    logic [4:0]         output_count_reg;
    logic [15:0]        logistic_lut [256];

    dls_out_t expected_activations [$];
    int       mismatches    = 0;
    int       idle_cycles   = 0;
    int       stall_left    = 0;
    int       hold_requests = 0;
    int       hold_served   = 0;
    bit       quiet_tail    = 1'b0;

    dense_layer_sigmoid u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Logistic table: centre (2k+1)/32 of each signed top byte, rounded half up
    task automatic build_logistic_lut();
        longint unsigned powers [256];
        longint unsigned p;
        longint unsigned e;
        longint unsigned den;
        longint unsigned num;
        longint unsigned r;
        int k;
        int mm;
        p = 64'd1 << 32;
        powers[0] = p;
        for (int m = 1; m < 256; m++) begin
            p = (p * EXP_DECAY) >> 32;
            powers[m] = p;
        end
        for (int i = 0; i < 256; i++) begin
            k   = (i < 128) ? i : i - 256;
            mm  = (k >= 0) ? (2 * k + 1) : (-2 * k - 1);
            e   = powers[mm];
            den = (64'd1 << 32) + e;
            num = (k >= 0) ? (64'd1 << 48) : (e << 16);
            r   = (num + den / 2) / den;
            if (r > 64'd65535) begin
                r = 64'd65535;
            end
            logistic_lut[i] = r[15:0];
        end
    endtask

    function automatic int unsigned effective_count(input logic [4:0] v, input int unsigned maxv);
        if (v == 5'd0) begin
            return 1;
        end
        if (v > maxv) begin
            return maxv;
        end
        return v;
    endfunction

    function automatic logic [15:0] pick_value();
        if ($urandom_range(0, 4) == 0) begin
            return 16'($urandom);
        end
        return 16'($urandom_range(0, 4095)) - 16'd2048;
    endfunction

    // Update the shadow for one accepted request and queue any activations it causes
    task automatic apply_request(input dls_in_t item);
        int unsigned n;
        int unsigned nout;
        int unsigned base;
        longint      acc;
        longint      q;
        logic [15:0] sat;
        dls_out_t    res;
        n    = effective_count(input_count_reg, MAX_INPUTS);
        nout = effective_count(output_count_reg, MAX_OUTPUTS);
        if (item.op == OP_WEIGHT) begin
            if (item.weight_address < WMEM_DEPTH) begin
                weight_shadow[item.weight_address] = item.value;
                weight_loaded[item.weight_address] = 1'b1;
            end
            return;
        end
        if (elements_held >= n) begin
            elements_held = 0;
        end
        element_shadow[elements_held] = item.value;
        elements_held++;
        if (elements_held < n) begin
            return;
        end
        elements_held = 0;
        for (int unsigned o = 0; o < nout; o++) begin
            base = o * (n + 1);
            acc  = 0;
            for (int unsigned i = 0; i < n; i++) begin
                acc += longint'(weight_shadow[base + i]) * longint'(element_shadow[i]);
            end
            acc += longint'(weight_shadow[base + n]) * 4096;
            // floor shift back to Q4.12, then saturate
            q = acc >>> 12;
            if (q > 32767) begin
                q = 32767;
            end else if (q < -32768) begin
                q = -32768;
            end
            sat = q[15:0];
            res.neuron_index = 4'(o);
            res.activation   = logistic_lut[sat[15:8]];
            res.last_out     = (o == nout - 1);
            expected_activations = {expected_activations, res};
        end
    endtask

    // Offer one request, at times after a random gap; valid stays up between requests
    task automatic send_request(input dls_in_t item);
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        apply_request(item);
    endtask

    task automatic send_weight(input int unsigned addr, input logic [15:0] val);
        dls_in_t item;
        item.op             = OP_WEIGHT;
        item.weight_address = 9'(addr);
        item.value          = val;
        send_request(item);
    endtask

    // Load any weight the next vector reads but that was never written
    task automatic load_missing_weights();
        int unsigned n;
        int unsigned nout;
        int unsigned addr;
        n    = effective_count(input_count_reg, MAX_INPUTS);
        nout = effective_count(output_count_reg, MAX_OUTPUTS);
        for (int unsigned o = 0; o < nout; o++) begin
            for (int unsigned i = 0; i <= n; i++) begin
                addr = o * (n + 1) + i;
                if (!weight_loaded[addr]) begin
                    send_weight(addr, pick_value());
                end
            end
        end
    endtask

    task automatic send_element(input logic [15:0] val);
        dls_in_t     item;
        int unsigned n;
        int unsigned held;
        n    = effective_count(input_count_reg, MAX_INPUTS);
        held = (elements_held >= n) ? 0 : elements_held;
        if (held + 1 == n) begin
            load_missing_weights();
        end
        item.op             = OP_INPUT;
        item.weight_address = 9'($urandom);
        item.value          = val;
        send_request(item);
    endtask

    // Drain, settle, then write both count registers back to back
    task automatic write_counts(input logic [4:0] n_val, input logic [4:0] o_val);
        s_valid <= 1'b0;
        wait (expected_activations.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_INPUT_COUNT;
        cfg_wdata <= n_val;
        @(posedge aclk);
        cfg_index <= CFG_OUTPUT_COUNT;
        cfg_wdata <= o_val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        input_count_reg  = n_val;
        output_count_reg = o_val;
        elements_held    = 0;
    endtask

    // One random request: mostly elements and in-range weights, some stray addresses
    task automatic send_random_request();
        int unsigned n;
        int unsigned nout;
        int unsigned r;
        n    = effective_count(input_count_reg, MAX_INPUTS);
        nout = effective_count(output_count_reg, MAX_OUTPUTS);
        r    = $urandom_range(0, 99);
        if (r < 60) begin
            send_element(pick_value());
        end else if (r < 90) begin
            send_weight($urandom_range(0, nout * (n + 1) - 1), pick_value());
        end else begin
            send_weight($urandom_range(WMEM_DEPTH, 511), 16'($urandom));
        end
    endtask

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < 100) begin
            $display("mismatch: %s got %0d expected %0d", what, got, want);
        end
        mismatches++;
    endtask

    // Field extremes, saturation both ways, floor rounding of -1, stray addresses
    task automatic test_directed_extremes();
        write_counts(5'd1, 5'd2);
        send_weight(0, 16'h7FFF);
        send_weight(1, 16'h0000);
        send_weight(2, 16'h8000);
        send_weight(3, 16'h7FFF);
        send_element(16'h7FFF);
        send_element(16'h8000);
        send_element(16'h0000);
        send_weight(0, 16'h0001);
        send_weight(2, 16'h0000);
        send_weight(3, 16'h8000);
        send_element(16'hFFFF);
        send_element(16'h0001);
        send_weight(1, 16'h8000);
        send_weight(3, 16'h7FFF);
        send_element(16'h7FFF);
        send_weight(WMEM_DEPTH - 1, 16'h5A5A);
        send_weight(WMEM_DEPTH, 16'hFFFF);
        send_weight(511, 16'h8001);
        send_element(16'h1000);
    endtask

    // A register write drops a half-filled vector
    task automatic test_partial_vector_discard();
        write_counts(5'd4, 5'd3);
        send_element(pick_value());
        send_element(pick_value());
        write_counts(5'd4, 5'd3);
        repeat (4) send_element(pick_value());
    endtask

    // Hold results off for a long stretch while elements keep coming
    task automatic test_output_backpressure();
        write_counts(5'd2, 5'd16);
        load_missing_weights();
        hold_requests <= hold_requests + 1;
        repeat (8) send_element(pick_value());
    endtask

    // Oversized input count and zero output count: one full sixteen-element vector
    task automatic test_count_clamp();
        write_counts(5'd31, 5'd0);
        repeat (16) send_element(pick_value());
    endtask

    // Random traffic across a range of counts, clamped values among them
    task automatic test_random_counts();
        logic [4:0] n_set [8] = '{5'd0, 5'd3, 5'd7, 5'd2, 5'd17, 5'd4, 5'd1, 5'd5};
        logic [4:0] o_set [8] = '{5'd31, 5'd5, 5'd1, 5'd9, 5'd0, 5'd4, 5'd16, 5'd2};
        for (int p = 0; p < 8; p++) begin
            write_counts(n_set[p], o_set[p]);
            repeat (PHASE_ITEMS) send_random_request();
        end
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_steady_stream();
        write_counts(5'd5, 5'd8);
        quiet_tail <= 1'b1;
        repeat (PHASE_ITEMS) send_random_request();
        repeat (5) send_element(pick_value());
    endtask

    initial begin
        build_logistic_lut();
        elements_held    = 0;
        input_count_reg  = 5'd16;
        output_count_reg = 5'd16;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_extremes();
        test_partial_vector_discard();
        test_output_backpressure();
        test_count_clamp();
        test_random_counts();
        test_steady_stream();
        s_valid <= 1'b0;
        wait (expected_activations.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Receiver: random stall bursts, one long hold on request, none in the tail
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left <= 0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            stall_left  <= LONG_HOLD;
            m_ready     <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 10);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest expected activation
    always @(posedge aclk) begin
        dls_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_activations.size() == 0) begin
                report_mismatch("unexpected result, neuron", m_data.neuron_index, 0);
            end else begin
                want = expected_activations.pop_front();
                if (m_data.neuron_index !== want.neuron_index) begin
                    report_mismatch("neuron_index", m_data.neuron_index, want.neuron_index);
                end
                if (m_data.activation !== want.activation) begin
                    report_mismatch("activation", m_data.activation, want.activation);
                end
                if (m_data.last_out !== want.last_out) begin
                    report_mismatch("last_out", m_data.last_out, want.last_out);
                end
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// File: dense_layer_sigmoid.f
+incdir+hdl
hdl/dls_pkg.sv
hdl/dls_mac.sv
hdl/dense_layer_sigmoid.sv
tb/tb_dense_layer_sigmoid.sv
